/* hw/rtl/ecd_pkg.sv */
package ecd_pkg;

	// field widths of the request and result channels
	localparam int FLOOR_IN_W   = 6;
	localparam int INDEX_IN_W   = 2;
	localparam int CODE_W       = 2;
	localparam int CLASS_W      = 2;
	localparam int IN_DATA_W    = 16;
	localparam int OUT_DATA_W   = 8;

	localparam int DEF_NUM_CARS   = 4;
	localparam int DEF_NUM_FLOORS = 64;

	// motion and intent codes
	typedef enum logic [CODE_W-1:0] {
		DIR_UP   = 2'd0,
		DIR_DOWN = 2'd1,
		DIR_STOP = 2'd2,
		DIR_BAD  = 2'd3
	} dir_t;

	// command kinds
	typedef enum logic {
		CMD_UPDATE = 1'b0,
		CMD_CALL   = 1'b1
	} cmd_t;

	// result class codes
	localparam logic [CLASS_W-1:0] CLASS_ONE  = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_TWO  = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd2;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

/* hw/rtl/elevator_call_dispatch_top.sv */
// channel   dir  handshake              payload
// s_        in   s_tvalid / s_tready    s_tuser: command; s_tdata: car_index, floor,
//                                       car_motion, car_intent, call_direction
// m_        out  m_tvalid / m_tready    m_tdata: found, chosen_car, priority_class
//
// an update request: accept, then result load
// a call request: accept, then each car in turn, from car 0 up, through the
// shared compare/subtract unit, then result load
// the result sits in an output register, so a new request is taken while it waits
// arst_n clears the car table to floor 0, stopped, stopped and empties the result
// a stalled result holds the sequencer in its done state until the register frees
module elevator_call_dispatch_top
	import ecd_pkg::*;
#(
	parameter int NUM_CARS   = DEF_NUM_CARS,
	parameter int NUM_FLOORS = DEF_NUM_FLOORS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [1:0] car_index, [7:2] floor, [9:8] car_motion,
	                                         // [11:10] car_intent, [12] call_direction, rest 0
	input  logic                  s_tuser,   // [0] command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // [0] found, [2:1] chosen_car,
	                                         // [4:3] priority_class, rest 0
);

	// car index width and stored floor width
	localparam int CW  = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
	localparam int FLC = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;
	localparam int FW  = (FLC < FLOOR_IN_W) ? FLC : FLOOR_IN_W;

	// request fields
	logic [INDEX_IN_W-1:0] in_index;
	logic [FLOOR_IN_W-1:0] in_floor;
	logic [CODE_W-1:0]     in_motion;
	logic [CODE_W-1:0]     in_intent;
	logic                  in_dir;
	logic [FW-1:0]         in_floor_sat;
	logic                  in_accept;

	assign in_index  = s_tdata[1:0];
	assign in_floor  = s_tdata[7:2];
	assign in_motion = s_tdata[9:8];
	assign in_intent = s_tdata[11:10];
	assign in_dir    = s_tdata[12];
	assign in_accept = s_tvalid && s_tready;

	// floors above the top of the building saturate
	always_comb begin
		if (32'(in_floor) > NUM_FLOORS - 1) begin
			in_floor_sat = FW'(NUM_FLOORS - 1);
		end else begin
			in_floor_sat = in_floor[FW-1:0];
		end
	end

	// car status table
	logic [FW-1:0]     floor_q  [NUM_CARS];
	logic [CODE_W-1:0] motion_q [NUM_CARS];
	logic [CODE_W-1:0] intent_q [NUM_CARS];

	// sequencer and scan registers
	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [FW-1:0] call_floor_q;
	logic          call_dir_q;
	logic          found_q;
	logic          cls_q;       // 0 class one, 1 class two
	logic [CW-1:0] best_car_q;
	logic [FW-1:0] best_dist_q;

	// output register
	logic                  out_valid_q;
	logic                  out_found_q;
	logic [INDEX_IN_W-1:0] out_car_q;
	logic [CLASS_W-1:0]    out_class_q;

	// control
	logic upd_write;
	logic scan_start;
	logic scan_step;
	logic scan_last;
	logic out_load;

	// shared compare / subtract unit on the car under scan
	logic [FW-1:0]     cur_floor;
	logic [CODE_W-1:0] cur_motion;
	logic [CODE_W-1:0] cur_intent;
	logic              cur_below;
	logic              cur_above;
	logic [FW-1:0]     cur_dist;
	logic              cur_one;
	logic              cur_two;
	logic              cur_ok;
	logic              cur_cls;
	logic              cur_take;
	logic              want_up;
	logic              want_down;

	always_comb begin
		cur_floor  = floor_q[cnt_q];
		cur_motion = motion_q[cnt_q];
		cur_intent = intent_q[cnt_q];
		cur_below  = cur_floor <= call_floor_q;
		cur_above  = cur_floor >= call_floor_q;
		cur_dist   = cur_above ? (cur_floor - call_floor_q) : (call_floor_q - cur_floor);
		want_up    = (call_dir_q == 1'b0);
		want_down  = (call_dir_q == 1'b1);
		cur_one = (cur_motion == DIR_STOP) ||
			(cur_below && cur_motion == DIR_UP && cur_intent == DIR_UP && want_up) ||
			(cur_above && cur_motion == DIR_DOWN && cur_intent == DIR_DOWN && want_down);
		cur_two = (cur_above && cur_motion == DIR_DOWN && cur_intent == DIR_UP && want_up) ||
			(cur_below && cur_motion == DIR_UP && cur_intent == DIR_DOWN && want_down);
		cur_ok   = cur_one || cur_two;
		cur_cls  = !cur_one;
		// better class wins, then strictly nearer; equal distance keeps the lower index
		cur_take = cur_ok && (!found_q || (cur_cls < cls_q) ||
			(cur_cls == cls_q && cur_dist < best_dist_q));
	end

	assign scan_last = (cnt_q == CW'(NUM_CARS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = (s_tuser == CMD_CALL) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		s_tready   = 1'b0;
		upd_write  = 1'b0;
		scan_start = 1'b0;
		scan_step  = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				upd_write  = in_accept && (s_tuser == CMD_UPDATE) &&
					(32'(in_index) < NUM_CARS);
				scan_start = in_accept;
			end
			ST_SCAN: begin
				scan_step = 1'b1;
			end
			ST_DONE: begin
				out_load = !out_valid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// car table, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CARS; i++) begin
				floor_q[i]  <= '0;
				motion_q[i] <= DIR_STOP;
				intent_q[i] <= DIR_STOP;
			end
		end else if (upd_write) begin
			floor_q[CW'(in_index)]  <= in_floor_sat;
			motion_q[CW'(in_index)] <= in_motion;
			intent_q[CW'(in_index)] <= in_intent;
		end
	end

	// scan state; an update leaves found clear so its result reads as none
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else if (scan_start) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else if (scan_step) begin
			cnt_q <= scan_last ? '0 : cnt_q + 1'b1;
			if (cur_take) begin
				found_q <= 1'b1;
			end
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (scan_start) begin
			call_floor_q <= in_floor_sat;
			call_dir_q   <= in_dir;
			cls_q        <= 1'b0;
			best_car_q   <= '0;
			best_dist_q  <= '0;
		end else if (scan_step && cur_take) begin
			cls_q       <= cur_cls;
			best_car_q  <= cnt_q;
			best_dist_q <= cur_dist;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_found_q <= found_q;
			out_car_q   <= found_q ? INDEX_IN_W'(best_car_q) : '0;
			out_class_q <= found_q ? (cls_q ? CLASS_TWO : CLASS_ONE) : CLASS_NONE;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_class_q, out_car_q, out_found_q};

`ifndef SYNTHESIS
	// a result only appears after the done state loaded it
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result appeared outside the done state");

	// a call request always starts a scan at car zero
	a_call_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && s_tuser == CMD_CALL) |=> (state_q == ST_SCAN && cnt_q == '0))
		else $error("call request did not start a scan");

	// the scan index stays on a real car
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (32'(cnt_q) < NUM_CARS))
		else $error("scan index beyond the last car");

	// a not-found result carries car zero and no class
	a_none_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[2:1] == 2'd0 && m_tdata[4:3] == CLASS_NONE))
		else $error("not-found result with a car or class");

	// the table is never written while a scan is running
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !upd_write)
		else $error("table written during a scan");
`endif

endmodule
